// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int DEF_COLUMN_COUNT = 80;
   localparam int DEF_ROW_COUNT    = 25;

   localparam int KIND_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int COL_PORT_W = 7;
   localparam int ROW_PORT_W = 5;

   localparam logic [KIND_W-1:0] KIND_PUT_CHAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ     = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BS     = 8'h08;
   localparam logic [CHAR_W-1:0] BLANK_GLYPH = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_INIT_DRAIN,
      ST_IDLE,
      ST_DECODE,
      ST_BS_BLANK,
      ST_FILL,
      ST_SCROLL,
      ST_DRAIN,
      ST_RESPOND
   } ctl_state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_PUT_CHAR,
      DP_NEW_LINE,
      DP_BS_STEP,
      DP_BS_BLANK,
      DP_HOME,
      DP_READ
   } dp_op_type;

   typedef struct packed {
      logic      latch_req;
      dp_op_type op;
      logic      sweep_run;
      logic      sweep_fill;
      logic      sweep_init;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              is_newline;
      logic              is_bs;
      logic              at_origin;
      logic              col_last;
      logic              row_last;
      logic              sweep_last;
   } dp_status_type;

endpackage

// File: rtl/core/text_console_writer_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                                       Transfer
// request   start, busy, req_kind/char_code/read_*      start high while busy low
// response  rsp_strobe, rsp_cursor_*, rsp_cell_*        one cycle while rsp_strobe high
// csr       csr_wr_en, csr_wr_data                      every edge with csr_wr_en high
//
// Ordinary characters and newlines that need no scroll, reads and no-ops pass through
// the decode and respond states; backspace off the origin adds a blank-write state;
// scroll and clear walk every cell through the single write port of the grid memories
// and then drain before the response.
// After reset busy stays high while the grid is filled with blanks; csr writes are
// taken throughout. The receiver cannot stall.
module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
   parameter int ROW_COUNT    = DEF_ROW_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COL_PORT_W-1:0] req_read_col,
   input  logic [ROW_PORT_W-1:0] req_read_row,
   output logic                  rsp_strobe,
   output logic [COL_PORT_W-1:0] rsp_cursor_col,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [CHAR_W-1:0]     rsp_cell_glyph,
   output logic [ATTR_W-1:0]     rsp_cell_attr,
   input  logic                  csr_wr_en,
   input  logic [ATTR_W-1:0]     csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   tcw_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   tcw_datapath #(
      .COLUMN_COUNT (COLUMN_COUNT),
      .ROW_COUNT    (ROW_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_read_col   (req_read_col),
      .req_read_row   (req_read_row),
      .cmd            (cmd),
      .status         (status),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_glyph (rsp_cell_glyph),
      .rsp_cell_attr  (rsp_cell_attr)
   );

endmodule

// File: rtl/core/tcw_datapath.sv
`timescale 1ns / 1ps
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
   parameter int ROW_COUNT    = DEF_ROW_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [ATTR_W-1:0]     csr_wr_data,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COL_PORT_W-1:0] req_read_col,
   input  logic [ROW_PORT_W-1:0] req_read_row,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [COL_PORT_W-1:0] rsp_cursor_col,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [CHAR_W-1:0]     rsp_cell_glyph,
   output logic [ATTR_W-1:0]     rsp_cell_attr
);

   localparam int CW    = $clog2(COLUMN_COUNT);
   localparam int RW    = $clog2(ROW_COUNT);
   localparam int CELLS = COLUMN_COUNT * ROW_COUNT;
   localparam int AW    = $clog2(CELLS);

   logic [CHAR_W-1:0] glyph_mem [CELLS];
   logic [ATTR_W-1:0] attr_mem  [CELLS];

   logic [ATTR_W-1:0]     attr_ff;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [AW-1:0]         sweep_ff, sweep_in;
   logic [KIND_W-1:0]     rq_kind_ff;
   logic [CHAR_W-1:0]     rq_char_ff;
   logic [COL_PORT_W-1:0] rq_col_ff;
   logic [ROW_PORT_W-1:0] rq_row_ff;
   logic                  rq_hit_ff;
   logic                  pend_valid_ff;
   logic                  pend_copy_ff;
   logic                  pend_attr_en_ff;
   logic [AW-1:0]         pend_addr_ff;
   logic [ATTR_W-1:0]     pend_attr_ff;
   logic [CHAR_W-1:0]     rd_glyph_ff;
   logic [ATTR_W-1:0]     rd_attr_ff;

   logic              col_last, row_last, sweep_copy;
   logic [AW-1:0]     cur_addr, rq_addr, rd_addr, wr_addr;
   logic              glyph_we, attr_we;
   logic [CHAR_W-1:0] wr_glyph;
   logic [ATTR_W-1:0] wr_attr;

   assign col_last   = (col_ff == CW'(COLUMN_COUNT - 1));
   assign row_last   = (row_ff == RW'(ROW_COUNT - 1));
   assign sweep_copy = !cmd.sweep_fill && (sweep_ff < AW'(CELLS - COLUMN_COUNT));
   assign cur_addr   = AW'(row_ff) * AW'(COLUMN_COUNT) + AW'(col_ff);
   assign rq_addr    = rq_hit_ff ? AW'(rq_row_ff) * AW'(COLUMN_COUNT) + AW'(rq_col_ff)
                                 : '0;

   always_comb begin
      status.kind       = rq_kind_ff;
      status.is_newline = (rq_char_ff == CHAR_LF) || (rq_char_ff == CHAR_CR);
      status.is_bs      = (rq_char_ff == CHAR_BS);
      status.at_origin  = (col_ff == '0) && (row_ff == '0);
      status.col_last   = col_last;
      status.row_last   = row_last;
      status.sweep_last = (sweep_ff == AW'(CELLS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_wr_en) begin
         attr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         rq_kind_ff <= req_kind;
         rq_char_ff <= req_char_code;
         rq_col_ff  <= req_read_col;
         rq_row_ff  <= req_read_row;
         rq_hit_ff  <= (req_kind == KIND_READ) && (int'(req_read_col) < COLUMN_COUNT)
                       && (int'(req_read_row) < ROW_COUNT);
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      case (cmd.op)
         DP_PUT_CHAR, DP_NEW_LINE: begin
            if (cmd.op == DP_NEW_LINE || col_last) begin
               col_in = '0;
               if (!row_last) begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         DP_BS_STEP: begin
            if (col_ff == '0) begin
               col_in = CW'(COLUMN_COUNT - 1);
               row_in = row_ff - 1'b1;
            end else begin
               col_in = col_ff - 1'b1;
            end
         end
         DP_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign sweep_in = cmd.sweep_run ? sweep_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         sweep_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         sweep_ff      <= sweep_in;
         pend_valid_ff <= cmd.sweep_run;
      end
   end

   always_ff @(posedge clock) begin
      pend_copy_ff    <= sweep_copy;
      pend_attr_en_ff <= cmd.sweep_fill || sweep_copy;
      pend_addr_ff    <= sweep_ff;
      pend_attr_ff    <= cmd.sweep_init ? RESET_ATTR : attr_ff;
   end

   always_comb begin
      if (cmd.sweep_run) begin
         rd_addr = sweep_copy ? sweep_ff + AW'(COLUMN_COUNT) : '0;
      end else begin
         rd_addr = rq_addr;
      end
   end

   always_comb begin
      glyph_we = 1'b0;
      attr_we  = 1'b0;
      wr_addr  = cur_addr;
      wr_glyph = BLANK_GLYPH;
      wr_attr  = attr_ff;
      if (pend_valid_ff) begin
         glyph_we = 1'b1;
         attr_we  = pend_attr_en_ff;
         wr_addr  = pend_addr_ff;
         wr_glyph = pend_copy_ff ? rd_glyph_ff : BLANK_GLYPH;
         wr_attr  = pend_copy_ff ? rd_attr_ff : pend_attr_ff;
      end else if (cmd.op == DP_PUT_CHAR) begin
         glyph_we = 1'b1;
         attr_we  = 1'b1;
         wr_glyph = rq_char_ff;
      end else if (cmd.op == DP_BS_BLANK) begin
         glyph_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[wr_addr] <= wr_glyph;
      end
      if (attr_we) begin
         attr_mem[wr_addr] <= wr_attr;
      end
      rd_glyph_ff <= glyph_mem[rd_addr];
      rd_attr_ff  <= attr_mem[rd_addr];
   end

   assign rsp_cursor_col = COL_PORT_W'(col_ff);
   assign rsp_cursor_row = ROW_PORT_W'(row_ff);
   assign rsp_cell_glyph = rq_hit_ff ? rd_glyph_ff : '0;
   assign rsp_cell_attr  = rq_hit_ff ? rd_attr_ff : '0;

endmodule

// File: rtl/core/tcw_controller.sv
`timescale 1ns / 1ps
module tcw_controller
   import tcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_strobe,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd.latch_req  = 1'b0;
      cmd.op         = DP_NONE;
      cmd.sweep_run  = 1'b0;
      cmd.sweep_fill = 1'b1;
      cmd.sweep_init = 1'b0;
      busy           = (state_ff != ST_IDLE);
      rsp_strobe     = (state_ff == ST_RESPOND);
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep_run  = 1'b1;
            cmd.sweep_init = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_INIT_DRAIN;
            end
         end
         ST_INIT_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.latch_req = start;
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESPOND;
            unique case (status.kind)
               KIND_PUT_CHAR: begin
                  if (status.is_newline) begin
                     cmd.op = DP_NEW_LINE;
                     if (status.row_last) begin
                        state_in = ST_SCROLL;
                     end
                  end else if (status.is_bs) begin
                     if (!status.at_origin) begin
                        cmd.op   = DP_BS_STEP;
                        state_in = ST_BS_BLANK;
                     end
                  end else begin
                     cmd.op = DP_PUT_CHAR;
                     if (status.col_last && status.row_last) begin
                        state_in = ST_SCROLL;
                     end
                  end
               end
               KIND_CLEAR: begin
                  cmd.op   = DP_HOME;
                  state_in = ST_FILL;
               end
               KIND_READ: begin
                  cmd.op = DP_READ;
               end
               default: begin
               end
            endcase
         end
         ST_BS_BLANK: begin
            cmd.op   = DP_BS_BLANK;
            state_in = ST_RESPOND;
         end
         ST_FILL: begin
            cmd.sweep_run = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_SCROLL: begin
            cmd.sweep_run  = 1'b1;
            cmd.sweep_fill = 1'b0;
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
